### src/ial_pkg.sv
// Shared types and constants of the indexed array list core.
package ial_pkg;

   localparam int FUNC_W     = 4;
   localparam int VALUE_W    = 32;
   localparam int READ_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int AT_W       = 13;
   localparam int CAPACITY_DEFAULT   = 256;
   localparam int WORD_WIDTH_DEFAULT = 32;

   typedef enum logic [FUNC_W-1:0] {
      FN_GET        = 4'd0,
      FN_SET        = 4'd1,
      FN_INSERT     = 4'd2,
      FN_REMOVE     = 4'd3,
      FN_PUSH_BACK  = 4'd4,
      FN_PUSH_FRONT = 4'd5,
      FN_POP_BACK   = 4'd6,
      FN_POP_FRONT  = 4'd7,
      FN_CLEAR      = 4'd8
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_BOUNDS = 2'd1,
      STAT_EMPTY  = 2'd2,
      STAT_FULL   = 2'd3
   } stat_type;

   typedef enum logic [1:0] {
      SM_IDLE,
      SM_WAIT,
      SM_EXEC
   } state_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic            wr;   // overwrite entry at 'at'
      logic            ins;  // open a gap at 'at', shift higher entries up
      logic            rem;  // close the gap at 'at', shift higher entries down
      logic [AT_W-1:0] at;
   } cell_ctl_type;

endpackage

### src/ial_cell.sv
// One list entry of the chain: holds a word and trades it with its neighbors.
module ial_cell #(
   parameter int IDX        = 0,
   parameter int WORD_WIDTH = 32
) (
   input  logic                     clock,
   input  ial_pkg::cell_ctl_type    ctl,
   input  logic [WORD_WIDTH-1:0]    value,
   input  logic [WORD_WIDTH-1:0]    lower_word,
   input  logic [WORD_WIDTH-1:0]    upper_word,
   input  logic [ial_pkg::AT_W-1:0] rd_idx,
   output logic [WORD_WIDTH-1:0]    word,
   output logic [WORD_WIDTH-1:0]    tap
);
   import ial_pkg::*;

   localparam logic [AT_W-1:0] MY_IDX = AT_W'(IDX);

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.wr && ctl.at == MY_IDX) begin
         word_in = value;
      end else if (ctl.ins) begin
         if (ctl.at == MY_IDX) begin
            word_in = value;
         end else if (MY_IDX > ctl.at) begin
            word_in = lower_word;
         end
      end else if (ctl.rem && MY_IDX >= ctl.at) begin
         word_in = upper_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   // Only the addressed cell drives the read tree.
   assign tap  = (rd_idx == MY_IDX) ? word_ff : '0;

endmodule

### src/ial_or_tree.sv
// Registered OR tree that collects the one selected cell word, one level per cycle.
module ial_or_tree #(
   parameter int LEAVES = 256,
   parameter int WIDTH  = 32
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] leaf [LEAVES],
   output logic [WIDTH-1:0] root
);
   localparam int LEVELS = $clog2(LEAVES);
   localparam int PAD    = 1 << LEVELS;

   logic [WIDTH-1:0] leaf_pad [PAD];
   logic [WIDTH-1:0] node_ff  [1:PAD-1];

   for (genvar j = 0; j < PAD; j++) begin : g_pad
      if (j < LEAVES) begin : g_real
         assign leaf_pad[j] = leaf[j];
      end else begin : g_zero
         assign leaf_pad[j] = '0;
      end
   end

   for (genvar k = 1; k < PAD; k++) begin : g_node
      if (2 * k >= PAD) begin : g_bottom
         always_ff @(posedge clock) begin
            node_ff[k] <= leaf_pad[2*k-PAD] | leaf_pad[2*k+1-PAD];
         end
      end else begin : g_inner
         always_ff @(posedge clock) begin
            node_ff[k] <= node_ff[2*k] | node_ff[2*k+1];
         end
      end
   end

   assign root = node_ff[1];

endmodule

### src/indexed_array_list_core.sv
// Top level of the indexed array list core: control, count and chain of cells.
// Usage:
//   Requests arrive on the req_ stream, one word per operation (get, set,
//   insert, remove, push or pop at either end, clear). Every request yields
//   exactly one response word on the rsp_ stream with the read data, a status
//   code and the element count after the operation. Storage is a chain of
//   CAPACITY cells; insert and remove shift every higher cell at once, on commit.
// Flow:
//   One request is in flight at a time. Writes (set, insert, remove, push,
//   clear) go straight from accept to commit; reads (get and both pops) first
//   wait while the selected cell word climbs a registered OR tree one level
//   per cycle. A new request is accepted only once the state has returned to
//   idle after the response is committed, so the core never takes a request
//   before it is through with the last one.
// Reset:
//   Synchronous, active high; the count drops to zero and no response is
//   pending. Cell contents are not cleared and are never read before written.
// Back pressure:
//   The response sits in an output register until rsp_tready; one more request
//   may be accepted meanwhile and is held until the output register frees up.
module indexed_array_list_core #(
   parameter int CAPACITY   = ial_pkg::CAPACITY_DEFAULT,
   parameter int WORD_WIDTH = ial_pkg::WORD_WIDTH_DEFAULT,
   localparam int CNT_W     = $clog2(CAPACITY + 1),
   localparam int REQ_BITS  = ial_pkg::FUNC_W + CNT_W + ial_pkg::VALUE_W,
   localparam int REQ_W     = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = ial_pkg::READ_W + ial_pkg::STATUS_W + CNT_W,
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // func, pos, value (low to high)
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // read_word, status, count (low to high)
);
   import ial_pkg::*;

   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int TREE_LEVELS = $clog2(CAPACITY);
   localparam int WAIT_W      = $clog2(TREE_LEVELS + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // Request fields
   func_type           req_func;
   logic [CNT_W-1:0]   req_pos;
   logic [VALUE_W-1:0] req_value;
   logic               req_fire;

   assign req_func  = func_type'(req_tdata[FUNC_W-1:0]);
   assign req_pos   = req_tdata[FUNC_W +: CNT_W];
   assign req_value = req_tdata[FUNC_W+CNT_W +: VALUE_W];
   assign req_fire  = req_tvalid && req_tready;

   // Control and operation registers
   state_type          state_ff, state_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   func_type           op_func_ff, op_func_in;
   logic [CNT_W-1:0]   op_pos_ff, op_pos_in;
   logic [VALUE_W-1:0] op_value_ff, op_value_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   // Execute-stage results
   logic               out_free;
   logic               commit;
   stat_type           ex_status;
   logic [CNT_W-1:0]   ex_used;
   logic               ex_read;
   logic [READ_W-1:0]  ex_word;
   cell_ctl_type       ex_ctl;
   cell_ctl_type       cell_ctl;
   logic [CNT_W-1:0]   used_m1;

   // Width adaption between the 32-bit stream fields and the cell words
   logic [WORD_WIDTH+VALUE_W-1:0] value_ext;
   logic [WORD_WIDTH-1:0]         cell_value;
   logic [WORD_WIDTH-1:0]         root_word;
   logic [READ_W+WORD_WIDTH-1:0]  root_ext;
   logic [READ_W-1:0]             root_read;

   assign value_ext  = {{WORD_WIDTH{1'b0}}, op_value_ff};
   assign cell_value = value_ext[WORD_WIDTH-1:0];
   assign root_ext   = {{READ_W{1'b0}}, root_word};
   assign root_read  = root_ext[READ_W-1:0];
   assign used_m1    = used_ff - CNT_W'(1);

   assign req_tready = (state_ff == SM_IDLE);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign commit     = (state_ff == SM_EXEC) && out_free;

   // Decide the outcome of the held operation against the current count.
   always_comb begin
      ex_status = STAT_OK;
      ex_used   = used_ff;
      ex_read   = 1'b0;
      ex_ctl    = '0;
      unique case (op_func_ff)
         FN_GET: begin
            if (op_pos_ff < used_ff) begin
               ex_read = 1'b1;
            end else begin
               ex_status = STAT_BOUNDS;
            end
         end
         FN_SET: begin
            if (op_pos_ff < used_ff) begin
               ex_ctl.wr = 1'b1;
               ex_ctl.at = AT_W'(op_pos_ff);
            end else begin
               ex_status = STAT_BOUNDS;
            end
         end
         FN_INSERT: begin
            if (op_pos_ff > used_ff) begin
               ex_status = STAT_BOUNDS;
            end else if (used_ff == CAP_CNT) begin
               ex_status = STAT_FULL;
            end else begin
               ex_ctl.ins = 1'b1;
               ex_ctl.at  = AT_W'(op_pos_ff);
               ex_used    = used_ff + CNT_W'(1);
            end
         end
         FN_REMOVE: begin
            if (op_pos_ff >= used_ff) begin
               ex_status = STAT_BOUNDS;
            end else begin
               ex_ctl.rem = 1'b1;
               ex_ctl.at  = AT_W'(op_pos_ff);
               ex_used    = used_m1;
            end
         end
         FN_PUSH_BACK: begin
            if (used_ff == CAP_CNT) begin
               ex_status = STAT_FULL;
            end else begin
               ex_ctl.ins = 1'b1;
               ex_ctl.at  = AT_W'(used_ff);
               ex_used    = used_ff + CNT_W'(1);
            end
         end
         FN_PUSH_FRONT: begin
            if (used_ff == CAP_CNT) begin
               ex_status = STAT_FULL;
            end else begin
               ex_ctl.ins = 1'b1;
               ex_used    = used_ff + CNT_W'(1);
            end
         end
         FN_POP_BACK: begin
            if (used_ff == '0) begin
               ex_status = STAT_EMPTY;
            end else begin
               ex_read = 1'b1;
               ex_used = used_m1;
            end
         end
         FN_POP_FRONT: begin
            if (used_ff == '0) begin
               ex_status = STAT_EMPTY;
            end else begin
               ex_read    = 1'b1;
               ex_ctl.rem = 1'b1;
               ex_used    = used_m1;
            end
         end
         FN_CLEAR: begin
            ex_used = '0;
         end
         default: begin
            // unused codes: no change
         end
      endcase
      ex_word = ex_read ? root_read : '0;
   end

   // Gate the cell command so the chain only moves on commit.
   always_comb begin
      cell_ctl     = ex_ctl;
      cell_ctl.wr  = ex_ctl.wr  && commit;
      cell_ctl.ins = ex_ctl.ins && commit;
      cell_ctl.rem = ex_ctl.rem && commit;
   end

   // Sequencer: accept, wait for the read tree (reads only), commit.
   always_comb begin
      state_in      = state_ff;
      wait_in       = wait_ff;
      used_in       = used_ff;
      op_func_in    = op_func_ff;
      op_pos_in     = op_pos_ff;
      op_value_in   = op_value_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      unique case (state_ff)
         SM_IDLE: begin
            if (req_fire) begin
               op_func_in  = req_func;
               op_pos_in   = req_pos;
               op_value_in = req_value;
               unique case (req_func)
                  FN_POP_BACK:  rd_idx_in = used_m1[IDX_W-1:0];
                  FN_POP_FRONT: rd_idx_in = '0;
                  default:      rd_idx_in = req_pos[IDX_W-1:0];
               endcase
               if (req_func == FN_GET || req_func == FN_POP_BACK ||
                   req_func == FN_POP_FRONT) begin
                  wait_in  = WAIT_W'(TREE_LEVELS - 1);
                  state_in = SM_WAIT;
               end else begin
                  state_in = SM_EXEC;
               end
            end
         end
         SM_WAIT: begin
            if (wait_ff == '0) begin
               state_in = SM_EXEC;
            end else begin
               wait_in = wait_ff - WAIT_W'(1);
            end
         end
         SM_EXEC: begin
            if (out_free) begin
               used_in       = ex_used;
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_W'({ex_used, ex_status, ex_word});
               state_in      = SM_IDLE;
            end
         end
         default: begin
            state_in = SM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SM_IDLE;
         used_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      wait_ff      <= wait_in;
      op_func_ff   <= op_func_in;
      op_pos_ff    <= op_pos_in;
      op_value_ff  <= op_value_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Chain of cells
   logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
   logic [WORD_WIDTH-1:0] cell_tap  [CAPACITY];
   logic [AT_W-1:0]       rd_idx_at;

   assign rd_idx_at = AT_W'(rd_idx_ff);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] lower_w;
      logic [WORD_WIDTH-1:0] upper_w;
      if (i == 0) begin : g_first
         assign lower_w = '0;
      end else begin : g_lower
         assign lower_w = cell_word[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign upper_w = cell_word[i];
      end else begin : g_upper
         assign upper_w = cell_word[i+1];
      end
      ial_cell #(
         .IDX        (i),
         .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .value      (cell_value),
         .lower_word (lower_w),
         .upper_word (upper_w),
         .rd_idx     (rd_idx_at),
         .word       (cell_word[i]),
         .tap        (cell_tap[i])
      );
   end

   ial_or_tree #(
      .LEAVES (CAPACITY),
      .WIDTH  (WORD_WIDTH)
   ) u_tree (
      .clock (clock),
      .leaf  (cell_tap),
      .root  (root_word)
   );

endmodule

### src/ial_checker.sv
// Port-level checks of the indexed array list core and their bind.
module ial_checker #(
   parameter int CAPACITY   = ial_pkg::CAPACITY_DEFAULT,
   localparam int CNT_W     = $clog2(CAPACITY + 1),
   localparam int RSP_BITS  = ial_pkg::READ_W + ial_pkg::STATUS_W + CNT_W,
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata   // read_word, status, count (low to high)
);
   import ial_pkg::*;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [READ_W-1:0]   rsp_word;
   logic [STATUS_W-1:0] rsp_status;
   logic [CNT_W-1:0]    rsp_count;

   assign rsp_word   = rsp_tdata[READ_W-1:0];
   assign rsp_status = rsp_tdata[READ_W +: STATUS_W];
   assign rsp_count  = rsp_tdata[READ_W+STATUS_W +: CNT_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= CAP_CNT)
      else $error("count above capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == STAT_FULL |-> rsp_count == CAP_CNT)
      else $error("full status with spare room");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == STAT_EMPTY |-> rsp_count == '0)
      else $error("empty status with elements held");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != STAT_OK |-> rsp_word == '0)
      else $error("refused request returned data");

endmodule

bind indexed_array_list_core ial_checker #(
   .CAPACITY   (CAPACITY)
) u_ial_checker (.*);

### sim/indexed_array_list_core_tb.sv
// Self-checking testbench of the indexed array list core, stream driver and monitor.
`timescale 1ns / 100ps

module indexed_array_list_core_tb;
   import ial_pkg::*;

   localparam int CAP         = ial_pkg::CAPACITY_DEFAULT;
   localparam int CNT_W       = $clog2(CAP + 1);
   localparam int REQ_BITS    = FUNC_W + CNT_W + VALUE_W;
   localparam int REQ_W       = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = READ_W + STATUS_W + CNT_W;
   localparam int RSP_W       = ((RSP_BITS + 7) / 8) * 8;
   localparam int ITEM_TARGET = 1650;
   localparam int HOLD_CYCLES = 400;
   localparam int LIMIT       = 500000;

   typedef enum int {MODE_MIX, MODE_GROW, MODE_SHRINK} mix_mode_type;

   // Request word fields, func in the lowest bits.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [CNT_W-1:0]   pos;
      logic [FUNC_W-1:0]  func;
   } req_word_type;

   // Response word fields, read_word in the lowest bits.
   typedef struct packed {
      logic [CNT_W-1:0]    elem_count;
      logic [STATUS_W-1:0] status;
      logic [READ_W-1:0]   read_word;
   } rsp_word_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;   // func, pos, value (low to high)
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // read_word, status, count (low to high)

   indexed_array_list_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the list, updated as each request word is accepted.
   logic [READ_W-1:0] list_mem [CAP];
   int unsigned       list_count = 0;

   req_word_type req_backlog [$];
   rsp_word_type pending_rsp [$];

   int err_count     = 0;
   int items_made    = 0;
   int items_sent    = 0;
   int rsp_seen      = 0;
   int peak_count    = 0;
   int status_hits [4] = '{0, 0, 0, 0};
   int hold_requests = 0;
   int holds_done    = 0;
   int cycle_count   = 0;

   // Remove the entry at 'at' and close the gap.
   function automatic void drop_entry(int unsigned at);
      for (int unsigned k = at; k + 1 < list_count; k++) list_mem[k] = list_mem[k + 1];
      list_count--;
   endfunction

   // Apply one request to the shadow list and return the response it should produce.
   function automatic rsp_word_type apply_request(req_word_type r);
      rsp_word_type o;
      int unsigned  at;
      o.read_word = '0;
      o.status    = STAT_OK;
      case (r.func)
         FN_GET: begin
            if (r.pos < list_count) o.read_word = list_mem[r.pos];
            else o.status = STAT_BOUNDS;
         end
         FN_SET: begin
            if (r.pos < list_count) list_mem[r.pos] = r.value;
            else o.status = STAT_BOUNDS;
         end
         FN_INSERT, FN_PUSH_BACK, FN_PUSH_FRONT: begin
            if (r.func == FN_INSERT) at = 32'(r.pos);
            else if (r.func == FN_PUSH_BACK) at = list_count;
            else at = 0;
            // bounds check wins over the full check
            if (at > list_count) o.status = STAT_BOUNDS;
            else if (list_count >= CAP) o.status = STAT_FULL;
            else begin
               for (int unsigned k = list_count; k > at; k--) list_mem[k] = list_mem[k - 1];
               list_mem[at] = r.value;
               list_count++;
            end
         end
         FN_REMOVE: begin
            if (r.pos < list_count) drop_entry(32'(r.pos));
            else o.status = STAT_BOUNDS;
         end
         FN_POP_BACK: begin
            if (list_count == 0) o.status = STAT_EMPTY;
            else begin
               o.read_word = list_mem[list_count - 1];
               list_count--;
            end
         end
         FN_POP_FRONT: begin
            if (list_count == 0) o.status = STAT_EMPTY;
            else begin
               o.read_word = list_mem[0];
               drop_entry(0);
            end
         end
         FN_CLEAR: list_count = 0;
         default: ;  // unused codes change nothing
      endcase
      o.elem_count = list_count[CNT_W-1:0];
      return o;
   endfunction

   // Build one random request, biased by mode toward growing, shrinking or a mix.
   function automatic req_word_type make_request(mix_mode_type mode);
      req_word_type r;
      int unsigned  pick;
      pick = $urandom_range(0, 99);
      case (mode)
         MODE_GROW: begin
            if (pick < 30) r.func = FN_PUSH_BACK;
            else if (pick < 45) r.func = FN_PUSH_FRONT;
            else if (pick < 75) r.func = FN_INSERT;
            else if (pick < 85) r.func = FN_GET;
            else if (pick < 92) r.func = FN_SET;
            else if (pick < 96) r.func = FN_REMOVE;
            else r.func = FN_POP_BACK;
         end
         MODE_SHRINK: begin
            if (pick < 25) r.func = FN_POP_BACK;
            else if (pick < 50) r.func = FN_POP_FRONT;
            else if (pick < 80) r.func = FN_REMOVE;
            else if (pick < 90) r.func = FN_GET;
            else if (pick < 95) r.func = FN_SET;
            else r.func = FN_PUSH_BACK;
         end
         default: begin
            r.func = FUNC_W'($urandom_range(0, 15));
            // keep clears rare so the list keeps some depth
            if (r.func == FN_CLEAR && $urandom_range(0, 3) != 0) r.func = FN_GET;
         end
      endcase
      if ($urandom_range(0, 9) == 0) r.pos = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
      else if (r.func == FN_INSERT) r.pos = CNT_W'($urandom_range(0, list_count));
      else if (r.func == FN_GET || r.func == FN_SET || r.func == FN_REMOVE)
         r.pos = (list_count == 0) ? '0 : CNT_W'($urandom_range(0, list_count - 1));
      else r.pos = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
      pick = $urandom_range(0, 7);
      if (pick == 0) r.value = '0;
      else if (pick == 1) r.value = '1;
      else r.value = $urandom;
      return r;
   endfunction

   task automatic queue_req(func_type f, int unsigned p, logic [VALUE_W-1:0] v);
      req_word_type r;
      r.func  = f;
      r.pos   = CNT_W'(p);
      r.value = v;
      req_backlog.insert(req_backlog.size(), r);
      items_made++;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         err_count++;
      end
   endtask

   // Driver: bursts of request words with random gaps; hold each word until taken.
   req_word_type cur_req   = '0;
   int           burst_left = 0;
   int           gap_left   = 0;

   always @(posedge clock) begin
      logic         v_next;
      req_word_type d_next;
      req_word_type taken;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         v_next = req_tvalid;
         d_next = cur_req;
         if (req_tvalid && req_tready) begin
            taken = req_backlog[0];
            req_backlog.delete(0);
            pending_rsp.insert(pending_rsp.size(), apply_request(taken));
            items_sent++;
            v_next = 1'b0;
         end
         if (!v_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (req_backlog.size() > 0) begin
               d_next = req_backlog[0];
               v_next = 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         cur_req    = d_next;
         req_tvalid <= v_next;
         req_tdata  <= {{(REQ_W - REQ_BITS){1'b0}}, d_next};
      end
   end

   // Monitor: check each response word against the oldest prediction and pace rsp_tready.
   int hold_left    = 0;
   int pattern_left = 0;
   int pattern_mode = 0;
   int pattern_tick = 0;

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      logic         ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_BITS-1:0];
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %h", $time, got);
               err_count++;
            end else begin
               want = pending_rsp[0];
               pending_rsp.delete(0);
               check_field("read_word", want.read_word, got.read_word);
               check_field("status", want.status, got.status);
               check_field("count", want.elem_count, got.elem_count);
               status_hits[want.status]++;
               if (want.elem_count > peak_count) peak_count = int'(want.elem_count);
            end
         end
         pattern_tick++;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (holds_done < hold_requests) begin
            holds_done++;
            hold_left  = HOLD_CYCLES;
            ready_next = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern_mode = $urandom_range(0, 3);
               pattern_left = $urandom_range(5, 60);
            end
            pattern_left--;
            case (pattern_mode)
               0:       ready_next = 1'b1;
               1:       ready_next = 1'($urandom_range(0, 1));
               2:       ready_next = (pattern_tick % 4) != 0;
               default: ready_next = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
         $display("** indexed_array_list_core: FAILED **");
         $finish;
      end
   end

   // Stimulus: directed corner cases, then random phases that fill and drain the list.
   mix_mode_type mode;
   int           phase_idx  = 0;
   int           phase_made = 0;
   int           tail       = 0;
   int           chunk      = 0;
   logic         phase_done;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list: every read, remove and pop is refused
      queue_req(FN_GET, 0, 32'h0);
      queue_req(FN_SET, 0, 32'h1234_5678);
      queue_req(FN_REMOVE, 0, 32'h0);
      queue_req(FN_POP_BACK, 0, 32'h0);
      queue_req(FN_POP_FRONT, 0, 32'h0);
      queue_req(FN_INSERT, 1, 32'hDEAD_BEEF);
      queue_req(func_type'(4'd9), 511, 32'hFFFF_FFFF);
      queue_req(func_type'(4'd15), 256, 32'h0);
      // build a short list through every way in, then read, change, shrink and clear it
      queue_req(FN_PUSH_BACK, 0, 32'hFFFF_FFFF);
      queue_req(FN_PUSH_FRONT, 511, 32'h0);
      queue_req(FN_INSERT, 1, 32'hA5A5_A5A5);
      queue_req(FN_INSERT, 3, 32'h5A5A_5A5A);
      queue_req(FN_GET, 0, 32'h0);
      queue_req(FN_GET, 3, 32'h0);
      queue_req(FN_GET, 4, 32'h0);
      queue_req(FN_SET, 2, 32'h8000_0001);
      queue_req(FN_REMOVE, 1, 32'h0);
      queue_req(FN_GET, 511, 32'h0);
      queue_req(FN_GET, 256, 32'h0);
      queue_req(FN_INSERT, 5, 32'h0);
      queue_req(FN_POP_BACK, 0, 32'h0);
      queue_req(FN_POP_FRONT, 0, 32'h0);
      queue_req(FN_CLEAR, 0, 32'h0);
      queue_req(FN_GET, 0, 32'h0);
      queue_req(FN_PUSH_BACK, 0, 32'h0000_0001);

      // pause the sender until every response is back
      while (req_backlog.size() != 0 || pending_rsp.size() != 0) @(negedge clock);

      while (items_made < ITEM_TARGET) begin
         mode       = mix_mode_type'(phase_idx % 3);
         phase_made = 0;
         tail       = 0;
         phase_done = 1'b0;
         // on the first grow phases, stall the response side while requests keep coming
         if (mode == MODE_GROW && phase_idx < 6) hold_requests++;
         while (!phase_done && items_made < ITEM_TARGET) begin
            chunk = $urandom_range(1, 12);
            repeat (chunk) begin
               req_backlog.insert(req_backlog.size(), make_request(mode));
               items_made++;
               phase_made++;
            end
            // let the chunk drain so the next chunk sees the current count
            while (req_backlog.size() != 0) @(negedge clock);
            case (mode)
               MODE_GROW: begin
                  if (list_count == CAP) tail++;
                  phase_done = (tail >= 3) || (phase_made >= 700);
               end
               MODE_SHRINK: begin
                  if (list_count == 0) tail++;
                  phase_done = (tail >= 3) || (phase_made >= 700);
               end
               default: phase_done = (phase_made >= 150);
            endcase
         end
         if (mode == MODE_SHRINK)
            while (pending_rsp.size() != 0) @(negedge clock);
         phase_idx++;
      end

      // drain, then watch for stray responses over the longest read latency
      while (req_backlog.size() != 0 || pending_rsp.size() != 0) @(negedge clock);
      repeat ($clog2(CAP) + 12) @(negedge clock);
      if (pending_rsp.size() != 0) err_count++;

      $display("Ran %0d requests in %0d phases, %0d responses, peak count %0d of %0d",
               items_sent, phase_idx, rsp_seen, peak_count, CAP);
      $display("Status ok/bounds/empty/full: %0d/%0d/%0d/%0d, %0d long response hold-offs",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3], holds_done);
      if (err_count == 0) begin
         $display("** indexed_array_list_core: PASSED **");
      end else begin
         $display("** indexed_array_list_core: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
src/ial_pkg.sv
src/ial_cell.sv
src/ial_or_tree.sv
src/indexed_array_list_core.sv
src/ial_checker.sv
sim/indexed_array_list_core_tb.sv
